### rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the top-level engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define RSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define RSR_ASSERT_NEVER(lbl, cond, msg) \
  `RSR_ASSERT(lbl, !(cond), msg)

`endif

### rtl/rsr_pkg.sv
// Types and constants of the range symbol replace engine.
`timescale 1ns / 1ps
package rsr_pkg;

  localparam int BUFFER_LENGTH = 4096;
  localparam int BLOCK_SIZE    = 64;
  localparam int ALPHABET_SIZE = 26;
  localparam int POS_W         = $clog2(BUFFER_LENGTH);
  localparam int OFF_W         = $clog2(BLOCK_SIZE);
  localparam int BLK_W         = POS_W - OFF_W;
  localparam int BLOCK_COUNT   = BUFFER_LENGTH / BLOCK_SIZE;
  localparam int SYM_W         = 5;
  localparam int CMD_W         = 2;
  localparam int MAP_DEPTH     = BLOCK_COUNT * (2 ** SYM_W);

  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_SIZE - 1);
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(ALPHABET_SIZE - 1);
  localparam logic [SYM_W-1:0] SYM_LIM  = SYM_W'(ALPHABET_SIZE);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P_RD,
    ST_P_MAP,
    ST_P_WR,
    ST_M_RD,
    ST_M_WR,
    ST_R_MAP,
    ST_R_OUT
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             set_valid;
    logic             clr_valid;
    logic [BLK_W-1:0] blk;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] wdata;
  } map_req_t;

endpackage

### rtl/rsr_if.sv
// Request and response channel interfaces of the range symbol replace engine.
`timescale 1ns / 1ps
interface rsr_req_if import rsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [SYM_W-1:0] symbol_in;
  logic [POS_W-1:0] left;
  logic [POS_W-1:0] right;
  logic [SYM_W-1:0] from_symbol;
  logic [SYM_W-1:0] to_symbol;

  modport source (output valid, command, position, symbol_in, left, right, from_symbol,
                  to_symbol, input ready);
  modport sink (input valid, command, position, symbol_in, left, right, from_symbol,
                to_symbol, output ready);
endinterface

interface rsr_rsp_if import rsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] read_position;
  logic [SYM_W-1:0] symbol_out;

  modport source (output valid, read_position, symbol_out, input ready);
  modport sink (input valid, read_position, symbol_out, output ready);
endinterface

### rtl/rsr_remap_store.sv
// Per-block remap table memory with row valid bits and identity fallback.
`timescale 1ns / 1ps
module rsr_remap_store import rsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_req_t         req_i,
  input  logic [BLK_W-1:0] query_blk_i,
  output logic             query_valid_o,
  output logic [SYM_W-1:0] value_o
);

  logic [SYM_W-1:0]       map_mem [MAP_DEPTH];
  logic [BLOCK_COUNT-1:0] row_valid_q;
  logic [SYM_W-1:0]       rd_q;
  logic [SYM_W-1:0]       sym_q;
  logic                   hit_q;
  logic [BLK_W+SYM_W-1:0] addr;

  assign addr          = {req_i.blk, req_i.sym};
  assign query_valid_o = row_valid_q[query_blk_i];
  assign value_o       = hit_q ? rd_q : sym_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      map_mem[addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q  <= map_mem[addr];
      sym_q <= req_i.sym;
      hit_q <= row_valid_q[req_i.blk] && (req_i.sym < SYM_LIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (req_i.set_valid) begin
      row_valid_q[req_i.blk] <= 1'b1;
    end else if (req_i.clr_valid) begin
      row_valid_q[req_i.blk] <= 1'b0;
    end
  end

endmodule

### rtl/range_symbol_replace_engine.sv
// Top level: symbol buffer with lazily remapped blocks, load, range replace and read.
// Read: store read, map lookup, result load once the output is free; then a new request.
// Load: direct write into an untouched block, else fold it by P_RD, P_MAP, P_WR per offset.
// Replace: folds partial or single blocks, then rewrites each full block's map per symbol.
// Both memories have registered reads; the remap memory has a single shared address port.
// Reset clears the row valid bits at once, so every map reads as identity; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module range_symbol_replace_engine import rsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsr_req_if.sink   req_i,
  rsr_rsp_if.source rsp_o
);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [POS_W-1:0] pos_q, pos_d, l_q, l_d, r_q, r_d;
  logic [SYM_W-1:0] sym_in_q, sym_in_d, from_q, from_d, to_q, to_d;
  logic [BLK_W-1:0] blk_q, blk_d, rb_q, rb_d, full_lo_q, full_lo_d, full_hi_q, full_hi_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [SYM_W-1:0] sidx_q, sidx_d;
  logic             right_pend_q, right_pend_d, full_pend_q, full_pend_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;

  logic [SYM_W-1:0] sym_mem [BUFFER_LENGTH];
  logic [SYM_W-1:0] sym_rd_q;
  logic             sym_re, sym_we;
  logic [POS_W-1:0] sym_raddr, sym_waddr;
  logic [SYM_W-1:0] sym_wdata;

  map_req_t         map_req;
  logic             row_valid;
  logic [SYM_W-1:0] map_val;
  logic [BLK_W-1:0] query_blk;

  logic             accept, out_free;
  cmd_e             req_cmd;
  logic [BLK_W-1:0] pos_blk, lb, rb, lo_full, hi_full;
  logic             empty, single, left_part, right_part, full_ne;
  logic [POS_W-1:0] cur_pos;
  logic [SYM_W-1:0] edit_val;

  rsr_remap_store u_remap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (map_req),
    .query_blk_i   (query_blk),
    .query_valid_o (row_valid),
    .value_o       (map_val)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_cmd     = cmd_e'(req_i.command);
  assign pos_blk     = req_i.position[POS_W-1:OFF_W];
  assign lb          = req_i.left[POS_W-1:OFF_W];
  assign rb          = req_i.right[POS_W-1:OFF_W];
  assign empty       = req_i.left > req_i.right;
  assign single      = (lb == rb);
  assign left_part   = (req_i.left[OFF_W-1:0] != '0);
  assign right_part  = (req_i.right[OFF_W-1:0] != OFF_LAST);
  assign lo_full     = left_part ? lb + BLK_W'(1) : lb;
  assign hi_full     = right_part ? rb - BLK_W'(1) : rb;
  assign full_ne     = (lo_full <= hi_full);
  assign query_blk   = (state_q == ST_IDLE) ? pos_blk : blk_q;
  assign cur_pos     = {blk_q, off_q};

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_position = out_pos_q;
  assign rsp_o.symbol_out    = out_sym_q;

  always_comb begin
    if ((cmd_q == CMD_LOAD) && (cur_pos == pos_q)) begin
      edit_val = sym_in_q;
    end else if ((cmd_q == CMD_REPLACE) && (cur_pos >= l_q) && (cur_pos <= r_q) &&
                 (map_val == from_q)) begin
      edit_val = to_q;
    end else begin
      edit_val = map_val;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_cmd)
            CMD_LOAD:    state_d = row_valid ? ST_P_RD : ST_IDLE;
            CMD_REPLACE: begin
              if (empty) begin
                state_d = ST_IDLE;
              end else if (single || left_part || right_part) begin
                state_d = ST_P_RD;
              end else begin
                state_d = ST_M_RD;
              end
            end
            CMD_READ:    state_d = ST_R_MAP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_P_RD:  state_d = ST_P_MAP;
      ST_P_MAP: state_d = ST_P_WR;
      ST_P_WR: begin
        if (off_q != OFF_LAST) begin
          state_d = ST_P_RD;
        end else if ((cmd_q == CMD_REPLACE) && right_pend_q) begin
          state_d = ST_P_RD;
        end else if ((cmd_q == CMD_REPLACE) && full_pend_q) begin
          state_d = ST_M_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_M_RD: state_d = ST_M_WR;
      ST_M_WR: begin
        if (sidx_q != SYM_LAST || blk_q != full_hi_q) begin
          state_d = ST_M_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_R_MAP: state_d = ST_R_OUT;
      ST_R_OUT: state_d = out_free ? ST_IDLE : ST_R_OUT;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d        = cmd_q;
    pos_d        = pos_q;
    sym_in_d     = sym_in_q;
    l_d          = l_q;
    r_d          = r_q;
    from_d       = from_q;
    to_d         = to_q;
    blk_d        = blk_q;
    rb_d         = rb_q;
    full_lo_d    = full_lo_q;
    full_hi_d    = full_hi_q;
    off_d        = off_q;
    sidx_d       = sidx_q;
    right_pend_d = right_pend_q;
    full_pend_d  = full_pend_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_pos_d    = out_pos_q;
    out_sym_d    = out_sym_q;
    sym_re       = 1'b0;
    sym_we       = 1'b0;
    sym_raddr    = cur_pos;
    sym_waddr    = cur_pos;
    sym_wdata    = edit_val;
    map_req      = '0;
    map_req.blk  = blk_q;
    map_req.sym  = sym_rd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = req_cmd;
          pos_d     = req_i.position;
          sym_in_d  = req_i.symbol_in;
          l_d       = req_i.left;
          r_d       = req_i.right;
          from_d    = req_i.from_symbol;
          to_d      = req_i.to_symbol;
          off_d     = '0;
          sidx_d    = '0;
          unique case (req_cmd)
            CMD_LOAD: begin
              blk_d = pos_blk;
              if (!row_valid) begin
                sym_we    = 1'b1;
                sym_waddr = req_i.position;
                sym_wdata = req_i.symbol_in;
              end
            end
            CMD_REPLACE: begin
              rb_d         = rb;
              full_lo_d    = lo_full;
              full_hi_d    = hi_full;
              right_pend_d = !single && left_part && right_part;
              full_pend_d  = !single && full_ne;
              if (single || left_part) begin
                blk_d = lb;
              end else if (right_part) begin
                blk_d = rb;
              end else begin
                blk_d = lo_full;
              end
            end
            CMD_READ: begin
              blk_d     = pos_blk;
              sym_re    = 1'b1;
              sym_raddr = req_i.position;
            end
            default: ;
          endcase
        end
      end
      ST_P_RD: sym_re = 1'b1;
      ST_P_MAP: map_req.rd_en = 1'b1;
      ST_P_WR: begin
        sym_we = 1'b1;
        if (off_q == OFF_LAST) begin
          map_req.clr_valid = 1'b1;
          off_d             = '0;
          if (right_pend_q) begin
            right_pend_d = 1'b0;
            blk_d        = rb_q;
          end else begin
            blk_d  = full_lo_q;
            sidx_d = '0;
          end
        end else begin
          off_d = off_q + OFF_W'(1);
        end
      end
      ST_M_RD: begin
        map_req.rd_en = 1'b1;
        map_req.sym   = sidx_q;
      end
      ST_M_WR: begin
        map_req.wr_en = 1'b1;
        map_req.sym   = sidx_q;
        map_req.wdata = (map_val == from_q) ? to_q : map_val;
        if (sidx_q == SYM_LAST) begin
          map_req.set_valid = 1'b1;
          sidx_d            = '0;
          blk_d             = blk_q + BLK_W'(1);
        end else begin
          sidx_d = sidx_q + SYM_W'(1);
        end
      end
      ST_R_MAP: map_req.rd_en = 1'b1;
      ST_R_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_sym_d   = map_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    if (sym_re) begin
      sym_rd_q <= sym_mem[sym_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      right_pend_q <= 1'b0;
      full_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      off_q        <= '0;
      sidx_q       <= '0;
    end else begin
      state_q      <= state_d;
      right_pend_q <= right_pend_d;
      full_pend_q  <= full_pend_d;
      out_valid_q  <= out_valid_d;
      off_q        <= off_d;
      sidx_q       <= sidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    sym_in_q  <= sym_in_d;
    l_q       <= l_d;
    r_q       <= r_d;
    from_q    <= from_d;
    to_q      <= to_d;
    blk_q     <= blk_d;
    rb_q      <= rb_d;
    full_lo_q <= full_lo_d;
    full_hi_q <= full_hi_d;
    out_pos_q <= out_pos_d;
    out_sym_q <= out_sym_d;
  end

  `RSR_ASSERT(a_read_enters_map, (accept && (req_i.command == CMD_READ)) |=> (state_q == ST_R_MAP), "Read request did not start the map lookup.")
  `RSR_ASSERT(a_rsp_from_read, $rose(out_valid_q) |-> ($past(state_q) == ST_R_OUT), "Response appeared without a read in progress.")
  `RSR_ASSERT(a_read_delivers, ((state_q == ST_R_OUT) && !out_valid_q) |=> out_valid_q, "Read result was not loaded into a free response register.")
  `RSR_ASSERT_NEVER(a_no_map_write_in_pass, map_req.wr_en && (state_q != ST_M_WR), "Remap table written outside a full block update.")

endmodule
